[design/round_robin_quantum_scheduler_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the round-robin quantum scheduler.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RRQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rrqs_pkg.sv]
// ---------------------------------------------------------------------------
// rrqs_pkg
// Shared constants and types of the round-robin quantum scheduler.
// ---------------------------------------------------------------------------
package rrqs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ID_W  = 8;
  localparam int unsigned REM_W = 16;
  localparam int unsigned QNT_W = 8;
  localparam int unsigned EV_W  = 3;
  localparam int unsigned QC_W  = 5;

  localparam logic [QNT_W-1:0] QUANTUM_RESET = 8'd2;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_IDLE       = 3'd0,
    EV_DISPATCHED = 3'd1,
    EV_RAN        = 3'd2,
    EV_FINISHED   = 3'd3,
    EV_PREEMPTED  = 3'd4,
    EV_ACCEPTED   = 3'd5,
    EV_DROPPED    = 3'd6
  } event_e;

  // Request from the step logic to the ready queue.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [ID_W-1:0]  id;
    logic [REM_W-1:0] rem;
  } fifo_ctrl_t;

  // Status of the ready queue seen by the step logic.
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [ID_W-1:0]  head_id;
    logic [REM_W-1:0] head_rem;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_next;
  } fifo_stat_t;

endpackage

[design/rrqs_fifo.sv]
// ---------------------------------------------------------------------------
// rrqs_fifo
// Ready queue: circular buffer of job ids and remaining times with a count.
// ---------------------------------------------------------------------------
module rrqs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrqs_pkg::fifo_ctrl_t ctrl_i,
  output rrqs_pkg::fifo_stat_t stat_o
);

  logic [rrqs_pkg::ID_W-1:0]  ids_q [rrqs_pkg::QUEUE_DEPTH];
  logic [rrqs_pkg::REM_W-1:0] rem_q [rrqs_pkg::QUEUE_DEPTH];

  logic [rrqs_pkg::PTR_W-1:0] head_q, head_d;
  logic [rrqs_pkg::PTR_W-1:0] tail_q, tail_d;
  logic [rrqs_pkg::CNT_W-1:0] count_q, count_d;

  logic [rrqs_pkg::ID_W-1:0]  head_id_q;
  logic [rrqs_pkg::REM_W-1:0] head_rem_q;

  function automatic logic [rrqs_pkg::PTR_W-1:0] next_ptr(
    input logic [rrqs_pkg::PTR_W-1:0] p
  );
    return (p == rrqs_pkg::PTR_W'(rrqs_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ids_q[tail_q] <= ctrl_i.id;
      rem_q[tail_q] <= ctrl_i.rem;
    end
    // The head entry is read ahead into the head register from the next head pointer. A push into an empty queue
    // lands on the head slot, so its data goes straight to the head register.
    if (ctrl_i.push && (tail_q == head_d)) begin
      head_id_q  <= ctrl_i.id;
      head_rem_q <= ctrl_i.rem;
    end else begin
      head_id_q  <= ids_q[head_d];
      head_rem_q <= rem_q[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full       = (count_q == rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.head_id    = head_id_q;
  assign stat_o.head_rem   = head_rem_q;
  assign stat_o.count      = count_q;
  assign stat_o.count_next = count_d;

endmodule

[design/rrqs_step.sv]
// ---------------------------------------------------------------------------
// rrqs_step
// Running-job state and the per-item scheduling decision.
// ---------------------------------------------------------------------------
module rrqs_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        kind_i,
  input  logic [rrqs_pkg::ID_W-1:0]   job_id_i,
  input  logic [rrqs_pkg::REM_W-1:0]  run_time_i,
  input  logic [rrqs_pkg::QNT_W-1:0]  quantum_i,
  input  rrqs_pkg::fifo_stat_t        stat_i,
  output rrqs_pkg::fifo_ctrl_t        ctrl_o,
  output rrqs_pkg::event_e            event_o,
  output logic [rrqs_pkg::ID_W-1:0]   id_o,
  output logic [rrqs_pkg::REM_W-1:0]  rem_o,
  output logic                        run_valid_o
);

  logic                       run_vld_q, run_vld_d;
  logic [rrqs_pkg::ID_W-1:0]  run_id_q, run_id_d;
  logic [rrqs_pkg::REM_W-1:0] run_rem_q, run_rem_d;
  logic [rrqs_pkg::QNT_W-1:0] slice_q, slice_d;

  logic [rrqs_pkg::REM_W-1:0] rem_dec;
  logic [rrqs_pkg::QNT_W-1:0] slice_inc;

  assign rem_dec   = (run_rem_q == '0) ? '0 : run_rem_q - 1'b1;
  assign slice_inc = slice_q + 1'b1;

  always_comb begin
    run_vld_d  = run_vld_q;
    run_id_d   = run_id_q;
    run_rem_d  = run_rem_q;
    slice_d    = slice_q;
    ctrl_o     = '0;
    event_o    = rrqs_pkg::EV_IDLE;
    id_o       = '0;
    rem_o      = '0;
    if (kind_i == rrqs_pkg::KIND_ARRIVAL) begin
      ctrl_o.id  = job_id_i;
      ctrl_o.rem = run_time_i;
      id_o       = job_id_i;
      rem_o      = run_time_i;
      if (!stat_i.full) begin
        ctrl_o.push = fire_i;
        event_o     = rrqs_pkg::EV_ACCEPTED;
      end else begin
        event_o = rrqs_pkg::EV_DROPPED;
      end
    end else if (!run_vld_q) begin
      if (!stat_i.empty) begin
        ctrl_o.pop = fire_i;
        run_vld_d  = 1'b1;
        run_id_d   = stat_i.head_id;
        run_rem_d  = stat_i.head_rem;
        slice_d    = '0;
        event_o    = rrqs_pkg::EV_DISPATCHED;
        id_o       = stat_i.head_id;
        rem_o      = stat_i.head_rem;
      end
    end else begin
      run_rem_d = rem_dec;
      id_o      = run_id_q;
      rem_o     = rem_dec;
      if (rem_dec == '0) begin
        run_vld_d = 1'b0;
        slice_d   = '0;
        event_o   = rrqs_pkg::EV_FINISHED;
      end else if (slice_inc == quantum_i) begin
        // The slice restarts whether or not the requeue finds room.
        slice_d    = '0;
        ctrl_o.id  = run_id_q;
        ctrl_o.rem = rem_dec;
        if (!stat_i.full) begin
          ctrl_o.push = fire_i;
          run_vld_d   = 1'b0;
          event_o     = rrqs_pkg::EV_PREEMPTED;
        end else begin
          event_o = rrqs_pkg::EV_RAN;
        end
      end else begin
        slice_d = slice_inc;
        event_o = rrqs_pkg::EV_RAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
      run_id_q  <= '0;
      run_rem_q <= '0;
      slice_q   <= '0;
    end else if (fire_i) begin
      run_vld_q <= run_vld_d;
      run_id_q  <= run_id_d;
      run_rem_q <= run_rem_d;
      slice_q   <= slice_d;
    end
  end

  assign run_valid_o = run_vld_q;

endmodule

[design/round_robin_quantum_scheduler_unit.sv]
// Flow: an accepted item waits in the input register until the step fires, which loads
// the result register; the step is held while the result register is full and stalled;
// every item gives exactly one result.
// Throughput: one item per cycle while the output is not stalled; the step is
// combinational from input register via the ready queue update to the result register.
// Reset clears all control state and sets the quantum to 2; queue storage is not
// cleared and needs no reset pass.
// ---------------------------------------------------------------------------
// round_robin_quantum_scheduler_unit
// Round-robin job scheduler with a configurable time quantum.
// ---------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_unit_assert.svh"

module round_robin_quantum_scheduler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rrqs_pkg::QNT_W-1:0] time_quantum_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [rrqs_pkg::ID_W-1:0]  job_id_i,
  input  logic [rrqs_pkg::REM_W-1:0] run_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rrqs_pkg::EV_W-1:0]  event_res_o,
  output logic [rrqs_pkg::ID_W-1:0]  job_id_out_o,
  output logic [rrqs_pkg::REM_W-1:0] remaining_out_o,
  output logic [rrqs_pkg::QC_W-1:0]  queue_count_o
);

  logic [rrqs_pkg::QNT_W-1:0] quantum_q;

  logic                       in_vld_q;
  logic                       kind_q;
  logic [rrqs_pkg::ID_W-1:0]  id_q;
  logic [rrqs_pkg::REM_W-1:0] rt_q;

  logic                       out_vld_q;
  rrqs_pkg::event_e           ev_q;
  logic [rrqs_pkg::ID_W-1:0]  oid_q;
  logic [rrqs_pkg::REM_W-1:0] orem_q;
  logic [rrqs_pkg::QC_W-1:0]  oqc_q;

  logic                       step_ok;
  logic                       step_fire;
  logic                       in_take;
  rrqs_pkg::fifo_ctrl_t       fifo_ctrl;
  rrqs_pkg::fifo_stat_t       fifo_stat;
  rrqs_pkg::event_e           step_ev;
  logic [rrqs_pkg::ID_W-1:0]  step_id;
  logic [rrqs_pkg::REM_W-1:0] step_rem;
  logic                       run_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrqs_pkg::QUANTUM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      quantum_q <= time_quantum_i;
    end
  end

  // The registered item steps whenever the result register is free or draining.
  assign step_ok    = !out_vld_q || !out_stall_i;
  assign step_fire  = in_vld_q && step_ok;
  assign in_stall_o = in_vld_q && !step_ok;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      id_q   <= job_id_i;
      rt_q   <= run_time_i;
    end
  end

  rrqs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fifo_ctrl),
    .stat_o (fifo_stat)
  );

  rrqs_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (step_fire),
    .kind_i      (kind_q),
    .job_id_i    (id_q),
    .run_time_i  (rt_q),
    .quantum_i   (quantum_q),
    .stat_i      (fifo_stat),
    .ctrl_o      (fifo_ctrl),
    .event_o     (step_ev),
    .id_o        (step_id),
    .rem_o       (step_rem),
    .run_valid_o (run_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      ev_q   <= step_ev;
      oid_q  <= step_id;
      orem_q <= step_rem;
      oqc_q  <= rrqs_pkg::QC_W'(fifo_stat.count_next);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = ev_q;
  assign job_id_out_o    = oid_q;
  assign remaining_out_o = orem_q;
  assign queue_count_o   = oqc_q;

  `RRQS_ASSERT_NOW(a_count_in_range, clk_i, rst_ni, 1'b1,
    fifo_stat.count <= rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH), "queue count above depth")
  `RRQS_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, fifo_ctrl.pop,
    !fifo_stat.empty && !fifo_ctrl.push, "pop from empty queue or with push")
  `RRQS_ASSERT_NEXT(a_dispatch_runs, clk_i, rst_ni,
    step_fire && step_ev == rrqs_pkg::EV_DISPATCHED, run_valid, "dispatch left no job running")
  `RRQS_ASSERT_NOW(a_finish_zero, clk_i, rst_ni,
    out_vld_q && ev_q == rrqs_pkg::EV_FINISHED, orem_q == '0, "finished job with time left")

endmodule
